// ===== rtl/bpa_pkg.sv =====
// bitmap page allocator shared types, field widths and codes
package bpa_pkg;

    localparam int unsigned WIU_W          = 11;
    localparam int unsigned ADDR_W         = 27;
    localparam int unsigned FREE_W         = 16;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned PAGE_SHIFT     = 12;
    localparam int unsigned PAGES_PER_WORD = 32;
    localparam int unsigned BIT_W          = 5;
    localparam int unsigned WORD_LSB       = PAGE_SHIFT + BIT_W;
    localparam int unsigned FREE_WORD_W    = ADDR_W - WORD_LSB;
    localparam int unsigned PAGE_W         = ADDR_W - PAGE_SHIFT;

    typedef logic [PAGES_PER_WORD-1:0] t_word;
    typedef logic [STATUS_W-1:0]       t_status;

    localparam t_word FULL_WORD = 32'hFFFF_FFFF;

    localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_PAGE  = 2'd1;
    localparam t_status ST_BAD_FREE = 2'd2;

endpackage

// ===== rtl/bpa_if.sv =====
// request and response channel interfaces of the bitmap page allocator
interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [bpa_pkg::ADDR_W-1:0]    free_address;

    modport source (output valid, output kind, output free_address, input ready);
    modport sink   (input valid, input kind, input free_address, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    bpa_pkg::t_status              status;
    logic [bpa_pkg::ADDR_W-1:0]    page_address;
    logic [bpa_pkg::FREE_W-1:0]    free_pages;

    modport source (output valid, output status, output page_address, output free_pages,
                    input ready);
    modport sink   (input valid, input status, input page_address, input free_pages,
                    output ready);
endinterface

// ===== rtl/bitmap_page_allocator_core.sv =====
// bitmap page frame allocator: next-fit scan over a word bitmap with a word hint
//
// i_req carries one request: kind allocate or free, and the byte address to free.
// o_rsp returns one response per request: status, allocated page address and the
// free page count after the request. both channels use valid/ready.
// i_cfg_wr_en/i_cfg_wr_data set words_in_use and restart the allocator.
// the bitmap lives in a single-port memory with registered read data; every word
// visit is a read state then a check state through one shared check/update unit.
// free: read, check and done states lead from accept to response valid; a page
// beyond installed memory goes from accept straight to the done state.
// allocate: a read and a check state per word scanned from the hint up to the
// first non-full word, plus a read and a check per word the hint walk visits after
// the page word fills, then the done state. i_req.ready returns the cycle after the
// response is loaded, so a new request is taken only once the last one is through.
// one request is in flight at a time; a finished response waits in an output
// register, so the next request is taken while the receiver stalls, but that
// request's response waits until the register frees.
// after reset and after each words_in_use write the memory is cleared one word a
// cycle, all BITMAP_WORDS words, while i_req.ready is low.
module bitmap_page_allocator_core #(
    parameter int unsigned BITMAP_WORDS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bpa_pkg::WIU_W-1:0]       i_cfg_wr_data,
    bpa_req_if.sink                         i_req,
    bpa_rsp_if.source                       o_rsp
);

    localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned EW = $clog2(BITMAP_WORDS + 1);
    localparam int unsigned TW = EW + bpa_pkg::BIT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CHK = 4'd3;
    localparam logic [3:0] S_W_RD  = 4'd4;
    localparam logic [3:0] S_W_CHK = 4'd5;
    localparam logic [3:0] S_F_RD  = 4'd6;
    localparam logic [3:0] S_F_CHK = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    function automatic logic [EW-1:0] f_eff(input logic [bpa_pkg::WIU_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0) begin
            x = 32'd1;
        end else if (x > 32'(BITMAP_WORDS)) begin
            x = 32'(BITMAP_WORDS);
        end
        return x[EW-1:0];
    endfunction

    bpa_pkg::t_word                     r_bitmap [BITMAP_WORDS];
    bpa_pkg::t_word                     r_rdata;

    logic [3:0]                         r_state,    n_state;
    logic [AW-1:0]                      r_idx,      n_idx;
    logic [AW-1:0]                      r_hint,     n_hint;
    logic [TW-1:0]                      r_total,    n_total;
    logic [bpa_pkg::WIU_W-1:0]          r_wiu,      n_wiu;
    logic [bpa_pkg::BIT_W-1:0]          r_bit,      n_bit;
    bpa_pkg::t_status                   r_res_status, n_res_status;
    logic [bpa_pkg::ADDR_W-1:0]         r_res_addr,   n_res_addr;
    logic                               r_ov,       n_ov;
    bpa_pkg::t_status                   r_o_status, n_o_status;
    logic [bpa_pkg::ADDR_W-1:0]         r_o_addr,   n_o_addr;
    logic [bpa_pkg::FREE_W-1:0]         r_o_free,   n_o_free;

    logic                               w_en;
    bpa_pkg::t_word                     w_data;
    logic [EW-1:0]                      s_eff;
    logic [AW-1:0]                      s_next_wrap;
    logic                               s_last;
    bpa_pkg::t_word                     s_inv;
    bpa_pkg::t_word                     s_onehot;
    logic [bpa_pkg::BIT_W-1:0]          s_lz;
    logic [31:0]                        s_page32;
    logic [31:0]                        s_total32;
    logic [bpa_pkg::FREE_WORD_W-1:0]    s_free_word;

    // bitmap memory, one port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bitmap[r_idx] <= w_data;
        end
        r_rdata <= r_bitmap[r_idx];
    end

    always_comb begin
        s_eff       = f_eff(r_wiu);
        s_last      = (32'(r_idx) + 32'd1) >= 32'(s_eff);
        s_next_wrap = s_last ? '0 : r_idx + AW'(1);
        s_inv       = ~r_rdata;
        s_onehot    = s_inv & (~s_inv + bpa_pkg::t_word'(1));
        s_lz        = '0;
        for (int k = 0; k < 32; k++) begin
            if (s_onehot[k]) begin
                s_lz = s_lz | bpa_pkg::BIT_W'(k);
            end
        end
        s_page32    = (32'(r_idx) << bpa_pkg::BIT_W) | 32'(s_lz);
        s_total32   = 32'(r_total);
        s_free_word = i_req.free_address[bpa_pkg::ADDR_W-1:bpa_pkg::WORD_LSB];
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_hint       = r_hint;
        n_total      = r_total;
        n_wiu        = r_wiu;
        n_bit        = r_bit;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_ov         = r_ov;
        n_o_status   = r_o_status;
        n_o_addr     = r_o_addr;
        n_o_free     = r_o_free;
        w_en         = 1'b0;
        w_data       = r_rdata;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_en   = 1'b1;
                w_data = '0;
                if (r_idx == AW'(BITMAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.kind == bpa_pkg::KIND_FREE) begin
                        n_bit = i_req.free_address[bpa_pkg::WORD_LSB-1:bpa_pkg::PAGE_SHIFT];
                        if (32'(s_free_word) < 32'(s_eff)) begin
                            n_idx   = AW'(s_free_word);
                            n_state = S_F_RD;
                        end else begin
                            n_res_status = bpa_pkg::ST_BAD_FREE;
                            n_res_addr   = '0;
                            n_state      = S_DONE;
                        end
                    end else begin
                        n_idx   = r_hint;
                        n_state = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (r_rdata == bpa_pkg::FULL_WORD) begin
                    if (s_last) begin
                        n_res_status = bpa_pkg::ST_NO_PAGE;
                        n_res_addr   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_A_RD;
                    end
                end else begin
                    w_en         = 1'b1;
                    w_data       = r_rdata | s_onehot;
                    n_total      = r_total - TW'(1);
                    n_res_status = bpa_pkg::ST_OK;
                    n_res_addr   = {s_page32[bpa_pkg::PAGE_W-1:0],
                                    {bpa_pkg::PAGE_SHIFT{1'b0}}};
                    if ((r_rdata | s_onehot) != bpa_pkg::FULL_WORD) begin
                        n_hint  = r_idx;
                        n_state = S_DONE;
                    end else if (s_next_wrap == r_hint) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = s_next_wrap;
                        n_state = S_W_RD;
                    end
                end
            end
            S_W_RD: begin
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                if (r_rdata != bpa_pkg::FULL_WORD) begin
                    n_hint  = r_idx;
                    n_state = S_DONE;
                end else if (s_next_wrap == r_hint) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = s_next_wrap;
                    n_state = S_W_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                n_res_addr = '0;
                if (!r_rdata[r_bit]) begin
                    n_res_status = bpa_pkg::ST_BAD_FREE;
                end else begin
                    w_en         = 1'b1;
                    w_data       = r_rdata & ~(bpa_pkg::t_word'(1) << r_bit);
                    n_total      = r_total + TW'(1);
                    n_res_status = bpa_pkg::ST_OK;
                    if (r_hint > r_idx) begin
                        n_hint = r_idx;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_addr   = r_res_addr;
                    n_o_free   = s_total32[bpa_pkg::FREE_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a register write restarts the allocator
        if (i_cfg_wr_en) begin
            n_wiu   = i_cfg_wr_data;
            n_state = S_CLEAR;
            n_idx   = '0;
            n_hint  = '0;
            n_total = {f_eff(i_cfg_wr_data), {bpa_pkg::BIT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_hint  <= '0;
            r_wiu   <= bpa_pkg::WIU_RESET;
            r_total <= {f_eff(bpa_pkg::WIU_RESET), {bpa_pkg::BIT_W{1'b0}}};
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hint  <= n_hint;
            r_wiu   <= n_wiu;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit        <= n_bit;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_o_status   <= n_o_status;
        r_o_addr     <= n_o_addr;
        r_o_free     <= n_o_free;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.page_address = r_o_addr;
    assign o_rsp.free_pages   = r_o_free;

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) < 32'(s_eff))
        else $error("hint beyond installed words");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= (32'(s_eff) << bpa_pkg::BIT_W))
        else $error("free count above installed pages");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_CLEAR || r_state == S_A_CHK || r_state == S_F_CHK))
        else $error("bitmap written outside an update step");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != bpa_pkg::ST_OK) |-> (r_o_addr == '0))
        else $error("failed request carries a page address");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_CHK && w_en && !i_cfg_wr_en) |=> (r_total == $past(r_total) - TW'(1)))
        else $error("allocation did not take one page from the free count");

endmodule

// ===== tb/tb_bitmap_page_allocator_core.sv =====
// self-checking testbench for the bitmap page allocator core
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_core;

    localparam int unsigned BITMAP_WORDS = 1024;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_PCT     = 35;

    typedef struct {
        bpa_pkg::t_status             status;
        logic [bpa_pkg::ADDR_W-1:0]   page_address;
        logic [bpa_pkg::FREE_W-1:0]   free_pages;
    } t_alloc_result;

    class page_alloc_scoreboard;
        bpa_pkg::t_word               word_bits [BITMAP_WORDS];
        int unsigned                  word_free [BITMAP_WORDS];
        int unsigned                  pages_free;
        int unsigned                  hint_word;
        logic [bpa_pkg::WIU_W-1:0]    wiu_setting;
        t_alloc_result                expected_results [$];
        logic [bpa_pkg::ADDR_W-1:0]   held_pages [$];
        int unsigned                  mismatches;
        int unsigned                  checked;
        int unsigned                  pages_handed;
        int unsigned                  pages_returned;
        int unsigned                  full_refusals;
        int unsigned                  bad_frees;

        function new();
            mismatches     = 0;
            checked        = 0;
            pages_handed   = 0;
            pages_returned = 0;
            full_refusals  = 0;
            bad_frees      = 0;
            restart(bpa_pkg::WIU_RESET);
        endfunction

        function int unsigned active_words();
            if (wiu_setting == 0) return 1;
            if (wiu_setting > BITMAP_WORDS) return BITMAP_WORDS;
            return 32'(wiu_setting);
        endfunction

        function void restart(logic [bpa_pkg::WIU_W-1:0] wiu);
            wiu_setting = wiu;
            for (int k = 0; k < BITMAP_WORDS; k++) begin
                word_bits[k] = '0;
                word_free[k] = bpa_pkg::PAGES_PER_WORD;
            end
            pages_free = active_words() * bpa_pkg::PAGES_PER_WORD;
            hint_word  = 0;
            held_pages.delete();
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_request(logic kind, logic [bpa_pkg::ADDR_W-1:0] addr);
            int unsigned   words;
            int unsigned   i;
            int unsigned   b;
            int unsigned   h;
            int unsigned   steps;
            int unsigned   pg;
            int unsigned   w;
            int unsigned   bt;
            t_alloc_result r;
            words          = active_words();
            r.status       = bpa_pkg::ST_OK;
            r.page_address = '0;
            if (hint_word >= words) hint_word = 0;
            if (kind == bpa_pkg::KIND_ALLOC) begin
                i = hint_word;
                while (i < words && word_bits[i] == bpa_pkg::FULL_WORD) i++;
                if (i >= words) begin
                    r.status = bpa_pkg::ST_NO_PAGE;
                    full_refusals++;
                end else begin
                    b = 0;
                    while (b < 31 && word_bits[i][b]) b++;
                    word_bits[i][b] = 1'b1;
                    if (word_free[i] > 0) word_free[i]--;
                    if (pages_free > 0) pages_free--;
                    r.page_address = bpa_pkg::ADDR_W'(
                        (i * bpa_pkg::PAGES_PER_WORD + b) << bpa_pkg::PAGE_SHIFT);
                    held_pages.push_back(r.page_address);
                    // hint walks forward past full words, one lap at most
                    h     = hint_word;
                    steps = 0;
                    while (steps < words && word_free[h] == 0) begin
                        h = (h + 1) % words;
                        steps++;
                    end
                    if (word_free[h] != 0) hint_word = h;
                    pages_handed++;
                end
            end else begin
                pg = 32'(addr) >> bpa_pkg::PAGE_SHIFT;
                w  = pg / bpa_pkg::PAGES_PER_WORD;
                bt = pg % bpa_pkg::PAGES_PER_WORD;
                if (w >= words || !word_bits[w][bt]) begin
                    r.status = bpa_pkg::ST_BAD_FREE;
                    bad_frees++;
                end else begin
                    word_bits[w][bt] = 1'b0;
                    if (word_free[w] < bpa_pkg::PAGES_PER_WORD) word_free[w]++;
                    pages_free++;
                    if (hint_word > w) hint_word = w;
                    for (int k = 0; k < held_pages.size(); k++) begin
                        if (held_pages[k] ==
                            {addr[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT], 12'h000}) begin
                            held_pages.delete(k);
                            break;
                        end
                    end
                    pages_returned++;
                end
            end
            r.free_pages = bpa_pkg::FREE_W'(pages_free);
            expected_results.push_back(r);
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
        endfunction

        function void check_response(bpa_pkg::t_status st, logic [bpa_pkg::ADDR_W-1:0] pa,
                                     logic [bpa_pkg::FREE_W-1:0] fp);
            t_alloc_result want;
            checked++;
            if (expected_results.size() == 0) begin
                flag("response with no request pending", 64'd0, 64'(pa));
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status) flag("status", 64'(want.status), 64'(st));
            if (pa !== want.page_address)
                flag("page_address", 64'(want.page_address), 64'(pa));
            if (fp !== want.free_pages)
                flag("free_pages", 64'(want.free_pages), 64'(fp));
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [bpa_pkg::WIU_W-1:0]   cfg_wr_data;
    int unsigned                 cycle_count = 0;
    int unsigned                 sent_count = 0;
    int unsigned                 hold_left = 0;
    bit                          held_off = 1'b0;
    int unsigned                 settings_run;
    page_alloc_scoreboard        sb = new();

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    bitmap_page_allocator_core #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch.sink),
        .o_rsp         (rsp_ch.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) cycle_count++;

    function automatic bit calm_window();
        return sent_count >= 900 && sent_count < 1150;
    endfunction

    // response side: random stalls, one long hold-off so the block backs up
    always @(posedge clk) begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.page_address, rsp_ch.free_pages);
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!held_off && sb.checked == 600) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input logic kind, input logic [bpa_pkg::ADDR_W-1:0] addr);
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.free_address <= addr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(kind, addr);
        sent_count++;
        if (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid        <= 1'b0;
            req_ch.kind         <= 1'($urandom);
            req_ch.free_address <= bpa_pkg::ADDR_W'($urandom);
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_words_in_use(input logic [bpa_pkg::WIU_W-1:0] value);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.restart(value);
        settings_run++;
    endtask

    // alternating fill and drain runs, with some junk requests mixed in
    task automatic random_phase(input int unsigned count);
        int unsigned                  fill_pct;
        int unsigned                  run_left;
        int unsigned                  pg;
        int unsigned                  idx;
        logic [bpa_pkg::ADDR_W-1:0]   junk;
        fill_pct = 25;
        run_left = 0;
        repeat (count) begin
            if (run_left == 0) begin
                fill_pct = (fill_pct > 50) ? 25 : 85;
                run_left = $urandom_range(80, 20);
            end
            run_left--;
            junk = bpa_pkg::ADDR_W'($urandom);
            if ($urandom_range(99) < 12) begin
                send_request(1'($urandom), junk);
            end else if (sb.held_pages.size() == 0 || $urandom_range(99) < fill_pct) begin
                send_request(bpa_pkg::KIND_ALLOC, junk);
            end else if ($urandom_range(99) < 85) begin
                idx = $urandom_range(sb.held_pages.size() - 1);
                send_request(bpa_pkg::KIND_FREE,
                             sb.held_pages[idx] | bpa_pkg::ADDR_W'($urandom_range(4095)));
            end else begin
                pg = $urandom_range(sb.active_words() * bpa_pkg::PAGES_PER_WORD + 63);
                if (pg > 32767) pg = 32767;
                send_request(bpa_pkg::KIND_FREE, {15'(pg), 12'($urandom)});
            end
        end
    endtask

    initial begin
        int unsigned wiu_plan [8];
        int unsigned item_plan [8];
        wiu_plan  = '{1, 0, 3, 2047, 5, 2, 1024, 7};
        item_plan = '{150, 150, 250, 250, 300, 150, 150, 150};
        settings_run        = 1;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= bpa_pkg::KIND_ALLOC;
        req_ch.free_address <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // full installed memory after reset
        send_request(bpa_pkg::KIND_ALLOC, bpa_pkg::ADDR_W'($urandom));
        send_request(bpa_pkg::KIND_ALLOC, bpa_pkg::ADDR_W'($urandom));
        send_request(bpa_pkg::KIND_FREE, 27'h0000FFF);
        send_request(bpa_pkg::KIND_FREE, 27'h0000000);
        send_request(bpa_pkg::KIND_ALLOC, 27'h7FFFFFF);
        send_request(bpa_pkg::KIND_FREE, 27'h7FFFFFF);
        send_request(bpa_pkg::KIND_FREE, 27'h0001ABC);
        send_request(bpa_pkg::KIND_ALLOC, 27'h0000000);
        send_request(bpa_pkg::KIND_FREE, 27'h0001000);
        random_phase(230);

        for (int p = 0; p < 8; p++) begin
            write_words_in_use(bpa_pkg::WIU_W'(wiu_plan[p]));
            if (p == 0) begin
                // frees beyond installed memory, then a free, an allocate and a free within it
                send_request(bpa_pkg::KIND_FREE, 27'h0020000);
                send_request(bpa_pkg::KIND_FREE, 27'h7FFF000);
                send_request(bpa_pkg::KIND_FREE, 27'h0000000);
                send_request(bpa_pkg::KIND_ALLOC, 27'h7FFFFFF);
                send_request(bpa_pkg::KIND_FREE, 27'h0000FFF);
            end
            random_phase(item_plan[p]);
        end

        quiesce();
        $display("%0d requests over %0d words_in_use settings; %0d responses checked",
                 sent_count, settings_run, sb.checked);
        $display("pages handed out %0d, returned %0d, refused as full %0d, bad frees %0d",
                 sb.pages_handed, sb.pages_returned, sb.full_refusals, sb.bad_frees);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== bitmap_page_allocator_core.f =====
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bitmap_page_allocator_core.sv
tb/tb_bitmap_page_allocator_core.sv
